@@ sv/ioaa_pkg.sv @@
`timescale 1ns / 1ps

package ioaa_pkg;

    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int KIND_WIDTH = 3;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_REM = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KIND_WIDTH-1:0] kind;
        logic                  saturate;
        logic signed [31:0]    operand_a;
        logic signed [31:0]    operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic               overflow;
        logic               div_by_zero;
    } t_out_word;

endpackage

@@ sv/ioaa_cell.sv @@
`timescale 1ns / 1ps

// One stage of the chain. Every cell restores one quotient bit of the
// magnitude division and adds one shifted partial product of the magnitude
// multiply, then hands the whole item to its neighbor.
module ioaa_cell
    import ioaa_pkg::*;
#(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
    parameter int STEP       = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [KIND_WIDTH-1:0]   i_kind,
    input  logic                    i_sat,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    input  logic [DATA_WIDTH-1:0]   i_ma,
    input  logic [DATA_WIDTH-1:0]   i_mb,
    input  logic [DATA_WIDTH:0]     i_rem,
    input  logic [DATA_WIDTH-1:0]   i_quo,
    input  logic [2*DATA_WIDTH-1:0] i_prod,
    output logic                    o_vld,
    output logic [KIND_WIDTH-1:0]   o_kind,
    output logic                    o_sat,
    output logic [DATA_WIDTH-1:0]   o_a,
    output logic [DATA_WIDTH-1:0]   o_b,
    output logic [DATA_WIDTH-1:0]   o_ma,
    output logic [DATA_WIDTH-1:0]   o_mb,
    output logic [DATA_WIDTH:0]     o_rem,
    output logic [DATA_WIDTH-1:0]   o_quo,
    output logic [2*DATA_WIDTH-1:0] o_prod
);

    localparam int BIT = DATA_WIDTH - 1 - STEP;

    logic [DATA_WIDTH:0]     n_rem_sh;
    logic [DATA_WIDTH:0]     n_diff;
    logic [DATA_WIDTH:0]     n_rem;
    logic [DATA_WIDTH-1:0]   n_quo;
    logic [2*DATA_WIDTH-1:0] n_prod;
    logic                    r_vld;

    always_comb begin
        n_rem_sh = {i_rem[DATA_WIDTH-1:0], i_ma[BIT]};
        n_diff   = n_rem_sh - {1'b0, i_mb};
        n_quo    = i_quo;
        if (!n_diff[DATA_WIDTH]) begin
            n_rem      = n_diff;
            n_quo[BIT] = 1'b1;
        end else begin
            n_rem = n_rem_sh;
        end
        n_prod = i_prod;
        if (i_mb[BIT]) begin
            n_prod = i_prod + ({{DATA_WIDTH{1'b0}}, i_ma} << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        o_kind <= i_kind;
        o_sat  <= i_sat;
        o_a    <= i_a;
        o_b    <= i_b;
        o_ma   <= i_ma;
        o_mb   <= i_mb;
        o_rem  <= n_rem;
        o_quo  <= n_quo;
        o_prod <= n_prod;
    end

    assign o_vld = r_vld;

endmodule

@@ sv/ioaa_final.sv @@
`timescale 1ns / 1ps

// Output stage: picks the result for the operation, sets the flags and clamps.
module ioaa_final
    import ioaa_pkg::*;
#(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [KIND_WIDTH-1:0]   i_kind,
    input  logic                    i_sat,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    input  logic [DATA_WIDTH:0]     i_rem,
    input  logic [DATA_WIDTH-1:0]   i_quo,
    input  logic [2*DATA_WIDTH-1:0] i_prod,
    output logic                    o_vld,
    output logic [DATA_WIDTH-1:0]   o_value,
    output logic                    o_ovf,
    output logic                    o_dz
);

    localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [DATA_WIDTH-1:0] n_value;
    logic                  n_ovf;
    logic                  n_dz;
    logic [DATA_WIDTH-1:0] n_sum;
    logic                  neg_a;
    logic                  neg_b;
    logic                  neg_p;
    logic [DATA_WIDTH-1:0] lo;
    logic                  hi_nz;
    logic                  r_vld;

    always_comb begin
        neg_a   = i_a[DATA_WIDTH-1];
        neg_b   = i_b[DATA_WIDTH-1];
        neg_p   = neg_a ^ neg_b;
        lo      = i_prod[DATA_WIDTH-1:0];
        hi_nz   = |i_prod[2*DATA_WIDTH-1:DATA_WIDTH];
        n_value = '0;
        n_ovf   = 1'b0;
        n_dz    = 1'b0;
        n_sum   = '0;
        case (i_kind)
            KIND_ADD, KIND_SUB: begin
                if (i_kind == KIND_ADD) begin
                    n_sum = i_a + i_b;
                    n_ovf = (neg_a == neg_b) && (n_sum[DATA_WIDTH-1] != neg_a);
                end else begin
                    n_sum = i_a - i_b;
                    n_ovf = (neg_a != neg_b) && (n_sum[DATA_WIDTH-1] != neg_a);
                end
                n_value = n_sum;
                if (n_ovf && i_sat) begin
                    n_value = neg_a ? MIN_V : MAX_V;
                end
            end
            KIND_MUL: begin
                n_value = neg_p ? (~lo + 1'b1) : lo;
                n_ovf   = hi_nz || (neg_p ? (lo > MIN_V) : (lo >= MIN_V));
                if (n_ovf && i_sat) begin
                    n_value = neg_p ? MIN_V : MAX_V;
                end
            end
            KIND_DIV, KIND_REM: begin
                if (i_b == '0) begin
                    n_ovf = 1'b1;
                    n_dz  = 1'b1;
                end else if (i_a == MIN_V && (&i_b)) begin
                    if (i_kind == KIND_DIV) begin
                        n_ovf   = 1'b1;
                        n_value = i_sat ? MAX_V : MIN_V;
                    end
                end else if (i_kind == KIND_DIV) begin
                    n_value = neg_p ? (~i_quo + 1'b1) : i_quo;
                end else begin
                    n_value = neg_a ? (~i_rem[DATA_WIDTH-1:0] + 1'b1)
                                    : i_rem[DATA_WIDTH-1:0];
                end
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        o_value <= n_value;
        o_ovf   <= n_ovf;
        o_dz    <= n_dz;
    end

    assign o_vld = r_vld;

endmodule

@@ sv/int32_overflow_aware_alu_core.sv @@
`timescale 1ns / 1ps

// Signed checked/saturating ALU: add, subtract, multiply, divide, remainder.
// Input channel: present a word on i_in while start is high; it is taken at
// that clock edge whenever busy is low. busy is tied low, so a word may be
// started in every cycle.
// Output channel: o_out is valid for exactly one cycle while o_done is high.
// The receiver has no way to stall it and must take it that cycle.
// The path from start to done runs through one input register, the chain of
// cells that resolves one quotient bit and one partial product per cell, and
// one output register.
// Throughput: one word per cycle, any mix of operations.
// Reset: i_rst_n low clears every valid bit in the chain; words in flight
// are dropped and no done pulse follows for them.
// The payload width is fixed at 32 bits by the word types.
module int32_overflow_aware_alu_core
    import ioaa_pkg::*;
#(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_done,
    output t_out_word o_out
);

    localparam int N = DATA_WIDTH;

    logic                  c_vld  [0:N];
    logic [KIND_WIDTH-1:0] c_kind [0:N];
    logic                  c_sat  [0:N];
    logic [N-1:0]          c_a    [0:N];
    logic [N-1:0]          c_b    [0:N];
    logic [N-1:0]          c_ma   [0:N];
    logic [N-1:0]          c_mb   [0:N];
    logic [N:0]            c_rem  [0:N];
    logic [N-1:0]          c_quo  [0:N];
    logic [2*N-1:0]        c_prod [0:N];

    logic          r_vld;
    logic [KIND_WIDTH-1:0] r_kind;
    logic          r_sat;
    logic [N-1:0]  r_a;
    logic [N-1:0]  r_b;
    logic [N-1:0]  n_a;
    logic [N-1:0]  n_b;
    logic [N-1:0]  fin_value;

    assign busy = 1'b0;
    assign n_a  = N'(i_in.operand_a);
    assign n_b  = N'(i_in.operand_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
        r_kind <= i_in.kind;
        r_sat  <= i_in.saturate;
        r_a    <= n_a;
        r_b    <= n_b;
    end

    assign c_vld[0]  = r_vld;
    assign c_kind[0] = r_kind;
    assign c_sat[0]  = r_sat;
    assign c_a[0]    = r_a;
    assign c_b[0]    = r_b;
    assign c_ma[0]   = r_a[N-1] ? (~r_a + 1'b1) : r_a;
    assign c_mb[0]   = r_b[N-1] ? (~r_b + 1'b1) : r_b;
    assign c_rem[0]  = '0;
    assign c_quo[0]  = '0;
    assign c_prod[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        ioaa_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .STEP      (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (c_vld[g]),
            .i_kind (c_kind[g]),
            .i_sat  (c_sat[g]),
            .i_a    (c_a[g]),
            .i_b    (c_b[g]),
            .i_ma   (c_ma[g]),
            .i_mb   (c_mb[g]),
            .i_rem  (c_rem[g]),
            .i_quo  (c_quo[g]),
            .i_prod (c_prod[g]),
            .o_vld  (c_vld[g+1]),
            .o_kind (c_kind[g+1]),
            .o_sat  (c_sat[g+1]),
            .o_a    (c_a[g+1]),
            .o_b    (c_b[g+1]),
            .o_ma   (c_ma[g+1]),
            .o_mb   (c_mb[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_quo  (c_quo[g+1]),
            .o_prod (c_prod[g+1])
        );
    end

    ioaa_final #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_final (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (c_vld[N]),
        .i_kind (c_kind[N]),
        .i_sat  (c_sat[N]),
        .i_a    (c_a[N]),
        .i_b    (c_b[N]),
        .i_rem  (c_rem[N]),
        .i_quo  (c_quo[N]),
        .i_prod (c_prod[N]),
        .o_vld  (o_done),
        .o_value(fin_value),
        .o_ovf  (o_out.overflow),
        .o_dz   (o_out.div_by_zero)
    );

    assign o_out.value = 32'(signed'(fin_value));

    // A zero divisor always raises overflow as well.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.div_by_zero |-> o_out.overflow)
        else $error("div_by_zero without overflow");

    // Division by zero always reports a zero value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.div_by_zero |-> o_out.value == '0)
        else $error("nonzero value on division by zero");

    // Each started word reaches the output after the full chain.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ##(N+1) o_done)
        else $error("word lost in chain");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ioaa_pkg::*;

    localparam int LATENCY = 34;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] MINUS_ONE = -32'sd1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_in = '0;
    logic      o_done;
    t_out_word o_out;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        gap_left = 0;
    bit        stimulus_done = 1'b0;

    int32_overflow_aware_alu_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_word compute_alu(t_in_word w);
        t_out_word r;
        logic signed [63:0] wide;
        logic signed [32:0] sum;
        logic [31:0] ma, mb;
        r = '0;
        case (w.kind)
            KIND_ADD, KIND_SUB: begin
                if (w.kind == KIND_ADD) begin
                    sum = 33'(w.operand_a) + 33'(w.operand_b);
                end else begin
                    sum = 33'(w.operand_a) - 33'(w.operand_b);
                end
                r.value = sum[31:0];
                r.overflow = sum[32] != sum[31];
                if (r.overflow && w.saturate) begin
                    r.value = w.operand_a[31] ? INT_MIN : INT_MAX;
                end
            end
            KIND_MUL: begin
                wide = 64'(w.operand_a) * 64'(w.operand_b);
                r.value = wide[31:0];
                r.overflow = wide != 64'(signed'(wide[31:0]));
                if (r.overflow && w.saturate) begin
                    r.value = (w.operand_a[31] != w.operand_b[31]) ? INT_MIN : INT_MAX;
                end
            end
            KIND_DIV, KIND_REM: begin
                if (w.operand_b == 0) begin
                    r.overflow = 1'b1;
                    r.div_by_zero = 1'b1;
                end else if (w.operand_a == INT_MIN && w.operand_b == MINUS_ONE) begin
                    if (w.kind == KIND_DIV) begin
                        r.overflow = 1'b1;
                        r.value = w.saturate ? INT_MAX : INT_MIN;
                    end
                end else begin
                    ma = w.operand_a[31] ? -w.operand_a : w.operand_a;
                    mb = w.operand_b[31] ? -w.operand_b : w.operand_b;
                    if (w.kind == KIND_DIV) begin
                        r.value = (w.operand_a[31] != w.operand_b[31]) ? -(ma / mb) : ma / mb;
                    end else begin
                        r.value = w.operand_a[31] ? -(ma % mb) : ma % mb;
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return MINUS_ONE;
            3: return 32'(0);
            4: return 32'($urandom_range(0, 20)) - 32'sd10;
            5: return 32'($urandom_range(0, 131071)) - 32'sd65536;
            6: return INT_MIN + 32'($urandom_range(0, 3));
            7: return INT_MAX - 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // A gap is absent half the time, otherwise mostly short and rarely long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic queue_word(logic [2:0] kind, logic sat, logic signed [31:0] a,
                              logic signed [31:0] b);
        t_in_word w;
        w.kind = kind;
        w.saturate = sat;
        w.operand_a = a;
        w.operand_b = b;
        pending_words.push_back(w);
    endtask

    initial begin
        logic [2:0] k;
        for (int s = 0; s < 2; s++) begin
            queue_word(KIND_ADD, 1'(s), INT_MAX, 32'sd1);
            queue_word(KIND_ADD, 1'(s), INT_MIN, MINUS_ONE);
            queue_word(KIND_SUB, 1'(s), 32'sd0, INT_MIN);
            queue_word(KIND_SUB, 1'(s), INT_MIN, 32'sd1);
            queue_word(KIND_MUL, 1'(s), INT_MIN, MINUS_ONE);
            queue_word(KIND_MUL, 1'(s), 32'sd65536, -32'sd32768);
            queue_word(KIND_DIV, 1'(s), INT_MIN, MINUS_ONE);
            queue_word(KIND_DIV, 1'(s), -32'sd7, 32'sd2);
            queue_word(KIND_DIV, 1'(s), 32'sd5, 32'sd0);
            queue_word(KIND_REM, 1'(s), INT_MIN, MINUS_ONE);
            queue_word(KIND_REM, 1'(s), -32'sd7, 32'sd2);
            queue_word(KIND_REM, 1'(s), INT_MAX, 32'sd0);
        end
        queue_word(3'd7, 1'b1, INT_MAX, INT_MAX);
        for (int i = 0; i < 1550; i++) begin
            k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            queue_word(k, 1'($urandom), pick_operand(), pick_operand());
        end
        stimulus_done = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 11) begin
            i_rst_n <= 1'b1;
        end
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_words.push_back(compute_alu(i_in));
            end
            if (start && busy) begin
                // Word not taken yet; keep holding it.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_in <= pending_words.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: value %0d", o_out.value);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out.value !== exp_w.value) begin
                    $error("value: expected %0d, actual %0d", exp_w.value, o_out.value);
                    error_count++;
                end
                if (o_out.overflow !== exp_w.overflow) begin
                    $error("overflow: expected %0b, actual %0b", exp_w.overflow,
                           o_out.overflow);
                    error_count++;
                end
                if (o_out.div_by_zero !== exp_w.div_by_zero) begin
                    $error("div_by_zero: expected %0b, actual %0b", exp_w.div_by_zero,
                           o_out.div_by_zero);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (pending_words.size() > 0 || start || expected_words.size() > 0) begin
            @(posedge i_clk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
